>>> hw/rtl/sppq_pkg.sv
// Package for the stable priority process queue.
// Holds sizes, operation and status codes, and the structs shared by the
// sequencer and the top level. No dependencies.
package sppq_pkg;

  localparam int unsigned QueueDepth = 32;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned IdW        = 5;
  localparam int unsigned PriW       = 8;
  localparam int unsigned EntryW     = IdW + PriW;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_PEEK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DUP       = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DRAIN = 4'b1000
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [PriW-1:0] pri;
  } entry_t;

  typedef struct packed {
    op_e             op;
    logic [IdW-1:0]  id;
    logic [PriW-1:0] pri;
  } request_t;

  typedef struct packed {
    status_e         status;
    logic [IdW-1:0]  id;
    logic [PriW-1:0] pri;
    logic            now_empty;
  } result_t;

endpackage

>>> hw/rtl/sppq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module sppq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sppq_ctrl.sv
// Sequencer for the priority queue: walks the slot RAM one entry a cycle
// to check duplicates, find the insert point and shift entries up or down.
// Depends on sppq_pkg.
module sppq_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  input  sppq_pkg::request_t               req_i,
  output logic                             req_ready_o,
  input  logic                             out_free_i,
  output logic                             res_valid_o,
  output sppq_pkg::result_t                res_o,
  output logic                             ram_we_o,
  output logic [sppq_pkg::IdxW-1:0]        ram_waddr_o,
  output sppq_pkg::entry_t                 ram_wdata_o,
  output logic [sppq_pkg::IdxW-1:0]        ram_raddr_o,
  input  sppq_pkg::entry_t                 ram_rdata_i
);
  import sppq_pkg::*;

  state_e          state_q, state_d;
  request_t        req_q, req_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] issue_q, issue_d;
  logic [CntW-1:0] lim_q, lim_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pend_idx_q, pend_idx_d;
  logic            dup_q, dup_d;
  logic            pos_found_q, pos_found_d;
  logic            found_q, found_d;
  entry_t          carry_q, carry_d;
  entry_t          hit_q, hit_d;

  logic accept;
  logic issue_en;
  logic scan_done;

  assign req_ready_o = (state_q == S_IDLE) && out_free_i;
  assign accept      = req_valid_i && req_ready_o;
  assign issue_en    = (state_q != S_IDLE) && (issue_q != lim_q);
  // all reads issued and the last read word consumed
  assign scan_done   = (issue_q == lim_q) && !pend_q;
  assign ram_raddr_o = issue_q[IdxW-1:0];

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    n_d         = n_q;
    issue_d     = issue_q;
    lim_d       = lim_q;
    pos_d       = pos_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    dup_d       = dup_q;
    pos_found_d = pos_found_q;
    found_d     = found_q;
    carry_d     = carry_q;
    hit_d       = hit_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = carry_q;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_DONE, id: '0, pri: '0, now_empty: 1'b0};

    if (issue_en) begin
      issue_d    = issue_q + CntW'(1);
      pend_d     = 1'b1;
      pend_idx_d = issue_q[IdxW-1:0];
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d       = req_i;
          issue_d     = '0;
          dup_d       = 1'b0;
          pos_found_d = 1'b0;
          found_d     = 1'b0;
          lim_d       = n_q;
          if (req_i.op == OP_INSERT) begin
            state_d = S_SCAN;
          end else begin
            if (req_i.op == OP_PEEK) begin
              lim_d = (n_q != '0) ? CntW'(1) : '0;
            end
            state_d = S_DRAIN;
          end
        end
      end

      S_SCAN: begin
        if (pend_q) begin
          if (ram_rdata_i.id == req_q.id) begin
            dup_d = 1'b1;
          end
          if (!pos_found_q && (ram_rdata_i.pri < req_q.pri)) begin
            pos_found_d = 1'b1;
            pos_d       = CntW'(pend_idx_q);
          end
        end
        if (scan_done) begin
          if (dup_q) begin
            res_valid_o = 1'b1;
            res_o       = '{status: ST_DUP, id: '0, pri: '0, now_empty: (n_q == '0)};
            state_d     = S_IDLE;
          end else begin
            issue_d = pos_found_q ? pos_q : n_q;
            lim_d   = n_q;
            carry_d = '{id: req_q.id, pri: req_q.pri};
            state_d = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // carry ripples one slot toward the tail per read word
        if (pend_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = pend_idx_q;
          ram_wdata_o = carry_q;
          carry_d     = ram_rdata_i;
        end
        if (scan_done) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
          if (n_q < CntW'(QueueDepth)) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = n_q[IdxW-1:0];
            ram_wdata_o = carry_q;
            n_d         = n_q + CntW'(1);
          end else begin
            // full row: the entry pushed off the tail is reported
            res_o.id  = carry_q.id;
            res_o.pri = carry_q.pri;
          end
        end
      end

      S_DRAIN: begin
        if (pend_q) begin
          if (!found_q) begin
            if ((req_q.op != OP_REMOVE) || (ram_rdata_i.id == req_q.id)) begin
              found_d = 1'b1;
              hit_d   = ram_rdata_i;
            end
          end else begin
            ram_we_o    = 1'b1;
            ram_waddr_o = pend_idx_q - IdxW'(1);
            ram_wdata_o = ram_rdata_i;
          end
        end
        if (scan_done) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
          if (found_q) begin
            res_o.id  = hit_q.id;
            res_o.pri = hit_q.pri;
            if (req_q.op == OP_PEEK) begin
              res_o.now_empty = (n_q == '0);
            end else begin
              n_d             = n_q - CntW'(1);
              res_o.now_empty = (n_q == CntW'(1));
            end
          end else begin
            res_o.status    = (req_q.op == OP_REMOVE) ? ST_NOT_FOUND : ST_EMPTY;
            res_o.now_empty = (n_q == '0);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      issue_q     <= '0;
      lim_q       <= '0;
      pend_q      <= 1'b0;
      dup_q       <= 1'b0;
      pos_found_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      issue_q     <= issue_d;
      lim_q       <= lim_d;
      pend_q      <= pend_d;
      dup_q       <= dup_d;
      pos_found_q <= pos_found_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    pos_q      <= pos_d;
    pend_idx_q <= pend_idx_d;
    carry_q    <= carry_d;
    hit_q      <= hit_d;
  end

endmodule

>>> hw/rtl/stable_priority_process_queue.sv
// Stable priority process queue: slots kept in descending priority in one RAM.
// Peek reads the head slot; pop and remove walk every entry held; insert scans every
// entry for a duplicate and the insert slot, then, unless a duplicate, shifts the entries
// from that slot toward the tail; each walk does one RAM read and write per cycle.
// One op in flight. Reset (async, active low) empties the queue; slots not cleared.
// Depends on sppq_pkg, sppq_ctrl, sppq_ram.
module stable_priority_process_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // opcode[1:0], proc_id[6:2], priority_req[14:7], pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // status[1:0], out_id[6:2], out_priority[14:7],
                                       // now_empty[15]
);
  import sppq_pkg::*;

  request_t        req;
  result_t         res;
  logic            res_valid;
  logic            out_free;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [IdxW-1:0] ram_raddr;
  entry_t          ram_wdata;
  entry_t          ram_rdata;
  logic            out_valid_q;
  result_t         out_q;

  assign req.op  = op_e'(s_axis_tdata_i[1:0]);
  assign req.id  = s_axis_tdata_i[6:2];
  assign req.pri = s_axis_tdata_i[14:7];

  assign out_free = !out_valid_q || m_axis_tready_i;

  sppq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_i       (req),
    .req_ready_o (s_axis_tready_o),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  sppq_ram #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result register; a new transfer is only taken once it is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.now_empty, out_q.pri, out_q.id, out_q.status};

  // a finished result never lands on one still waiting
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !out_valid_q)
    else $error("result produced while output register busy");

  a_ready_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!out_valid_q || m_axis_tready_i))
    else $error("input ready while result cannot drain");

  a_empty_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && (res.status == ST_EMPTY)) |-> (res.now_empty && (res.id == '0)))
    else $error("empty status with inconsistent fields");

  a_dup_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && (res.status == ST_DUP)) |-> (res.id == '0 && res.pri == '0))
    else $error("duplicate reject reports an entry");

endmodule
